/* design/tic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tic_pkg;

  localparam int NUM_DIMS        = 4;
  localparam int DIM_W           = 16;
  localparam int RANK_W          = 3;
  localparam int CIN_W           = 17;
  localparam int IDX_W           = 31;
  localparam int STRIDE_W        = 48;
  localparam int CNT_W           = 64;
  localparam int PROD_W          = CIN_W + STRIDE_W + 1;
  localparam int SUM_W           = PROD_W + 2;
  localparam int DIV_STEPS       = IDX_W;
  localparam int STEPS_PER_STAGE = 4;
  localparam int TOTAL_STEPS     = NUM_DIMS * DIV_STEPS;
  localparam int DIV_STAGES      = (TOTAL_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  typedef enum logic [RANK_W-1:0] {
    CFG_RANK = 3'd0,
    CFG_DIM0 = 3'd1,
    CFG_DIM1 = 3'd2,
    CFG_DIM2 = 3'd3,
    CFG_DIM3 = 3'd4
  } cfg_index_t;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic signed [CIN_W-1:0] cin_t;

  typedef struct packed {
    logic                req;
    logic                idx_bad;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    q;
    dim_t                r;
    dim_t [NUM_DIMS-1:0] coord;
    cin_t [NUM_DIMS-1:0] cin;
  } stage_t;

endpackage
`default_nettype wire

/* design/tensor_index_converter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Tensor index converter: turns a flat row-major index into per-dimension
// coordinates (req_type 0) or coordinates into a flat offset (req_type 1) for a
// tensor of up to four configured dimensions. One item is accepted every cycle
// while the output is not stalled. The index is divided by each dimension
// size in turn, last dimension first, one restoring quotient bit per step, four
// steps in each of 31 register stages behind the input register; a product stage
// and the output register follow. Each stage holds its item while the one ahead
// is full, so bubbles close up and a stall at the output loses nothing. Configure
// only when idle; strides and the element count settle through the stride1,
// stride0 and elem_count registers in turn after a register write.
module tensor_index_converter #(
  parameter int MAX_RANK = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic signed [31:0]            flat_index,
  input  wire logic signed [16:0]            coord_in_0,
  input  wire logic signed [16:0]            coord_in_1,
  input  wire logic signed [16:0]            coord_in_2,
  input  wire logic signed [16:0]            coord_in_3,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [30:0]                        flat_offset,
  output logic [15:0]                        coord_out_0,
  output logic [15:0]                        coord_out_1,
  output logic [15:0]                        coord_out_2,
  output logic [15:0]                        coord_out_3,
  output logic                               range_err
);
  import tic_pkg::*;

  localparam int RANK_CAP = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;

  // Configuration registers
  logic [RANK_W-1:0]   tensor_rank;
  dim_t [NUM_DIMS-1:0] dim_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_rank <= RANK_W'(1);
      for (int i = 0; i < NUM_DIMS; i++) dim_size[i] <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANK: tensor_rank <= cfg_data[RANK_W-1:0];
        CFG_DIM0: dim_size[0] <= cfg_data;
        CFG_DIM1: dim_size[1] <= cfg_data;
        CFG_DIM2: dim_size[2] <= cfg_data;
        CFG_DIM3: dim_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the rank, then treat every inactive dimension as size one so that it
  // leaves strides, count and divisions untouched.
  logic [RANK_W-1:0]   rank_eff;
  dim_t [NUM_DIMS-1:0] dim_eff;

  always_comb begin
    rank_eff = tensor_rank;
    if (rank_eff < RANK_W'(1)) rank_eff = RANK_W'(1);
    if (rank_eff > RANK_W'(RANK_CAP)) rank_eff = RANK_W'(RANK_CAP);
    for (int i = 0; i < NUM_DIMS; i++) begin
      dim_eff[i] = (RANK_W'(i) < rank_eff) ? dim_size[i] : DIM_W'(1);
    end
  end

  // Strides and element count: one multiplier per register, settling through
  // stride1, stride0 and elem_count in turn after any write.
  logic [2*DIM_W-1:0]  stride1;
  logic [STRIDE_W-1:0] stride0;
  logic [CNT_W-1:0]    elem_count;

  always_ff @(posedge clk) begin
    stride1    <= dim_eff[2] * dim_eff[3];
    stride0    <= STRIDE_W'(dim_eff[1]) * STRIDE_W'(stride1);
    elem_count <= CNT_W'(dim_eff[0]) * CNT_W'(stride0);
  end

  // Divider pipeline with per-stage hold
  stage_t              st [DIV_STAGES+1];
  logic [DIV_STAGES:0] vld;
  logic [DIV_STAGES+1:0] en;

  stage_t              m_st;
  logic                m_valid;
  logic signed [PROD_W-1:0] prod [NUM_DIMS];
  logic                en_m;
  logic                en_out;

  assign en_out               = !out_valid || out_ready;
  assign en_m                 = !m_valid || en_out;
  assign en[DIV_STAGES+1]     = en_m;
  assign in_ready             = en[0];

  for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  // Input register: drop inactive coordinates here.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].req     <= req_type;
      st[0].idx_bad <= flat_index[31];
      st[0].idx     <= flat_index[IDX_W-1:0];
      st[0].q       <= flat_index[IDX_W-1:0];
      st[0].r       <= '0;
      st[0].coord   <= '0;
      st[0].cin[0]  <= (rank_eff > RANK_W'(0)) ? coord_in_0 : '0;
      st[0].cin[1]  <= (rank_eff > RANK_W'(1)) ? coord_in_1 : '0;
      st[0].cin[2]  <= (rank_eff > RANK_W'(2)) ? coord_in_2 : '0;
      st[0].cin[3]  <= (rank_eff > RANK_W'(3)) ? coord_in_3 : '0;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    stage_t nx;

    always_comb begin
      int                 s;
      int                 pos;
      logic [1:0]         dim;
      dim_t               d;
      logic [DIM_W:0]     t;
      logic               ge;
      nx = st[k-1];
      t  = '0;
      ge = 1'b0;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        s   = (k - 1) * STEPS_PER_STAGE + j;
        pos = s % DIV_STEPS;
        dim = 2'(NUM_DIMS - 1 - s / DIV_STEPS);
        d   = dim_eff[dim];
        if (s < TOTAL_STEPS) begin
          if (pos == 0) nx.r = '0;
          t  = {nx.r, nx.q[IDX_W-1]};
          ge = t >= {1'b0, d};
          if (ge) t = t - {1'b0, d};
          nx.r = t[DIM_W-1:0];
          nx.q = {nx.q[IDX_W-2:0], ge};
          if (pos == DIV_STEPS - 1) nx.coord[dim] = nx.r;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) st[k] <= nx;
    end
  end

  // Product stage: coordinate times stride, one multiplier per dimension.
  logic [STRIDE_W-1:0] stride [NUM_DIMS];
  assign stride[3] = STRIDE_W'(1);
  assign stride[2] = STRIDE_W'(dim_eff[3]);
  assign stride[1] = STRIDE_W'(stride1);
  assign stride[0] = stride0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en_m) begin
      m_valid <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_m) begin
      m_st <= st[DIV_STAGES];
      for (int i = 0; i < NUM_DIMS; i++) begin
        prod[i] <= PROD_W'(st[DIV_STAGES].cin[i]) * PROD_W'($signed({1'b0, stride[i]}));
      end
    end
  end

  // Output register: sum, range check, zero the offset and coordinates on a bad item.
  logic signed [SUM_W-1:0] sum;
  logic                    bad;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_DIMS; i++) sum = sum + SUM_W'(prod[i]);
    if (m_st.req) begin
      bad = sum[SUM_W-1] || (sum > SUM_W'(33'h7FFF_FFFF)) ||
            (sum >= $signed({{(SUM_W-CNT_W){1'b0}}, elem_count}));
    end else begin
      bad = m_st.idx_bad || ({{(CNT_W-IDX_W){1'b0}}, m_st.idx} >= elem_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      range_err <= bad;
      if (bad) begin
        flat_offset <= '0;
      end else if (m_st.req) begin
        flat_offset <= sum[IDX_W-1:0];
      end else begin
        flat_offset <= m_st.idx;
      end
      coord_out_0 <= (bad || m_st.req) ? '0 : m_st.coord[0];
      coord_out_1 <= (bad || m_st.req) ? '0 : m_st.coord[1];
      coord_out_2 <= (bad || m_st.req) ? '0 : m_st.coord[2];
      coord_out_3 <= (bad || m_st.req) ? '0 : m_st.coord[3];
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_err |-> flat_offset == '0 && coord_out_0 == '0 &&
      coord_out_1 == '0 && coord_out_2 == '0 && coord_out_3 == '0)
    else $error("out-of-range item carries non-zero fields");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held while output register empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !m_valid)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

/* tb/tensor_index_checker.sv */
`timescale 1ns / 1ps
module tensor_index_checker
  import tic_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  cfg_index_t         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               req_type,
  input  logic signed [31:0] flat_index,
  input  logic signed [16:0] coord_in_0,
  input  logic signed [16:0] coord_in_1,
  input  logic signed [16:0] coord_in_2,
  input  logic signed [16:0] coord_in_3,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [30:0]        flat_offset,
  input  logic [15:0]        coord_out_0,
  input  logic [15:0]        coord_out_1,
  input  logic [15:0]        coord_out_2,
  input  logic [15:0]        coord_out_3,
  input  logic               range_err,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [30:0]      offset;
    logic [3:0][15:0] coord;
    logic             oor;
  } conv_result_t;

  logic [2:0]  rank_reg;
  logic [15:0] dims [4];
  conv_result_t expected_q [$];

  function automatic conv_result_t convert(input logic rq, input logic [31:0] idx,
                                           input logic [3:0][16:0] cin);
    conv_result_t res;
    int unsigned rk;
    longint unsigned total, rem, stride;
    logic signed [79:0] acc;
    res = '0;
    rk = (rank_reg < 1) ? 1 : (rank_reg > 4 ? 4 : rank_reg);
    total = 1;
    for (int i = 0; i < rk; i++) total *= dims[i];
    if (!rq) begin
      if (idx[31] || idx >= total) begin
        res.oor = 1'b1;
      end else begin
        res.offset = idx[30:0];
        rem = idx;
        for (int i = rk - 1; i >= 0; i--) begin
          res.coord[i] = 16'(rem % dims[i]);
          rem = rem / dims[i];
        end
      end
    end else begin
      // a term can approach 2^64 in magnitude, so sum in 80 bits
      acc = 0;
      stride = 1;
      for (int i = rk - 1; i >= 0; i--) begin
        acc += 80'(signed'(cin[i])) * 80'(stride);
        stride *= dims[i];
      end
      if (acc < 0 || acc >= total || acc > 80'h7FFF_FFFF)
        res.oor = 1'b1;
      else
        res.offset = acc[30:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    conv_result_t seen, want;
    if (rst) begin
      rank_reg <= 3'd1;
      for (int i = 0; i < 4; i++) dims[i] <= 16'd1;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RANK) rank_reg <= cfg_data[2:0];
        else if (cfg_index <= CFG_DIM3) dims[cfg_index - CFG_DIM0] <= cfg_data;
      end
      if (in_valid && in_ready)
        expected_q.push_back(convert(req_type, flat_index,
                                     {coord_in_3, coord_in_2, coord_in_1, coord_in_0}));
      if (out_valid && out_ready) begin
        seen = '{flat_offset, {coord_out_3, coord_out_2, coord_out_1, coord_out_0},
                 range_err};
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", seen);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("result mismatch: expected off=%0d c=%h oor=%b, got off=%0d c=%h oor=%b",
                       want.offset, want.coord, want.oor,
                       seen.offset, seen.coord, seen.oor);
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/tensor_index_converter_test.sv */
`timescale 1ns / 1ps
module tensor_index_converter_test;
  import tic_pkg::*;

  localparam int LATENCY     = 33;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  cfg_index_t         cfg_index = CFG_RANK;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = 1'b0;
  logic signed [31:0] flat_index = '0;
  logic signed [16:0] coord_in_0 = '0, coord_in_1 = '0, coord_in_2 = '0, coord_in_3 = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [30:0]        flat_offset;
  logic [15:0]        coord_out_0, coord_out_1, coord_out_2, coord_out_3;
  logic               range_err;
  int                 fail_count, pending;
  int                 cycle_count = 0;
  bit                 long_hold = 1'b0;
  logic [15:0]        cur_dims [4];
  int unsigned        cur_rank = 1;

  always #10 clk = ~clk;

  tensor_index_converter u_top (.*);
  tensor_index_checker u_check (.*);

  // Hang guard: stop the run if the pipeline wedges
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: own stall pattern, with a long hold-off on request so that
  // the pipeline fills and back-pressures the input
  always @(negedge clk) begin
    if (long_hold) begin
      out_ready <= 1'b0;
    end else begin
      case (($urandom >> 4) % 8)
        0, 1:    out_ready <= 1'b0;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Program a shape; then wait so strides settle
  task automatic set_shape(input int unsigned rk, input logic [15:0] d0, input logic [15:0] d1,
                           input logic [15:0] d2, input logic [15:0] d3);
    write_reg(CFG_RANK, rk[15:0]);
    write_reg(CFG_DIM0, d0);
    write_reg(CFG_DIM1, d1);
    write_reg(CFG_DIM2, d2);
    write_reg(CFG_DIM3, d3);
    cur_rank = (rk < 1) ? 1 : (rk > 4 ? 4 : rk);
    cur_dims = '{d0, d1, d2, d3};
    repeat (5) @(negedge clk);
  endtask

  // Offer one item and hold it until the handshake completes
  task automatic send_item(input logic rq, input logic [31:0] idx,
                           input logic [16:0] c0, input logic [16:0] c1,
                           input logic [16:0] c2, input logic [16:0] c3);
    in_valid   <= 1'b1;
    req_type   <= rq;
    flat_index <= idx;
    coord_in_0 <= c0;
    coord_in_1 <= c1;
    coord_in_2 <= c2;
    coord_in_3 <= c3;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid for a random gap at the end of a burst
  task automatic maybe_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic [16:0] rand_coord(input int d);
    case ($urandom_range(0, 9))
      0:       return 17'($urandom);
      1:       return 17'($urandom_range(0, 1) ? 17'h10000 : 17'h0FFFF);
      2:       return -17'sd1;
      default: return 17'($urandom_range(0, cur_dims[d] == 0 ? 0 : cur_dims[d] - 1));
    endcase
  endfunction

  task automatic random_item();
    longint unsigned total;
    logic [31:0] idx;
    total = 1;
    for (int i = 0; i < cur_rank; i++) total *= cur_dims[i];
    case ($urandom_range(0, 9))
      0:       idx = $urandom;
      1:       idx = 32'(total);
      default: idx = (total == 0) ? $urandom_range(0, 3)
                   : 32'($urandom_range(0, (total > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                 : 32'(total - 1)));
    endcase
    send_item(1'($urandom_range(0, 1)), idx, rand_coord(0), rand_coord(1),
              rand_coord(2), rand_coord(3));
    maybe_gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    cur_dims = '{16'd1, 16'd1, 16'd1, 16'd1};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes of both requests on a 3x5x7x9 tensor
    set_shape(4, 16'd3, 16'd5, 16'd7, 16'd9);
    send_item(1'b0, 32'd0, '0, '0, '0, '0);
    send_item(1'b0, 32'd944, '0, '0, '0, '0);
    send_item(1'b0, 32'd945, '0, '0, '0, '0);
    send_item(1'b0, 32'h8000_0000, '0, '0, '0, '0);
    send_item(1'b0, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send_item(1'b0, 32'h7FFF_FFFF, '0, '0, '0, '0);
    send_item(1'b1, '0, 17'd2, 17'd4, 17'd6, 17'd8);
    send_item(1'b1, '0, 17'd3, 17'd0, 17'd0, 17'd0);
    send_item(1'b1, '0, 17'd1, -17'sd1, 17'd0, 17'd0);
    send_item(1'b1, '0, 17'h10000, 17'h0FFFF, 17'h10000, 17'h0FFFF);
    send_item(1'b1, '0, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
    drain();

    // Zero-size dimension: everything is out of range
    set_shape(2, 16'd4, 16'd0, 16'd1, 16'd1);
    send_item(1'b0, 32'd0, '0, '0, '0, '0);
    send_item(1'b1, '0, '0, '0, '0, '0);
    drain();

    // Largest sizes: huge element count, large sums flagged out of range
    set_shape(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 32'h7FFF_FFFF, '0, '0, '0, '0);
    send_item(1'b1, '0, 17'd0, 17'd0, 17'h0FFFF, 17'h0FFFF);
    send_item(1'b1, '0, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
    send_item(1'b1, '0, 17'd0, 17'd1, 17'h10000, 17'd0);
    send_item(1'b1, '0, 17'h10000, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
    drain();

    // Rank zero and rank above four fold onto the legal range
    set_shape(0, 16'd100, 16'd7, 16'd7, 16'd7);
    send_item(1'b0, 32'd99, '0, '0, '0, '0);
    send_item(1'b1, '0, 17'd42, 17'd5, 17'd5, 17'd5);
    drain();
    set_shape(7, 16'd2, 16'd3, 16'd4, 16'd5);
    send_item(1'b0, 32'd119, '0, '0, '0, '0);
    drain();

    // Random phases across shapes; hold the receiver off in one of them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       set_shape(1, 16'hFFFF, 16'd1, 16'd1, 16'd1);
        1:       set_shape(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2:       set_shape(4, 16'd1, 16'd1, 16'd1, 16'd1);
        default: set_shape($urandom_range(0, 7), 16'($urandom_range(1, 300)),
                           16'($urandom_range(1, 300)), $urandom_range(0, 40) == 0 ? 16'd0 :
                           16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
      endcase
      if (ph == 4) begin
        fork
          begin
            long_hold = 1'b1;
            repeat (150) @(negedge clk);
            long_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 105; n++) random_item();
      drain();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tic_pkg.sv
design/tensor_index_converter.sv
tb/tensor_index_checker.sv
tb/tensor_index_converter_test.sv
